FILE: src/tclr_pkg.sv
// Shared constants, types and reply tables for the text command line responder.
package tclr_pkg;

    localparam int LINE_DEPTH = 16;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W      = $clog2(LINE_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [3:0] BLINK_PERIOD_RESET = 4'd2;

    typedef logic [3:0] reply_idx_t;

    typedef enum logic [1:0] {
        REPLY_OK,
        REPLY_MM,
        REPLY_TE
    } reply_code_t;

    function automatic reply_idx_t reply_len(input reply_code_t code);
        reply_idx_t len;
        unique case (code)
            REPLY_MM: len = 4'd9;
            default:  len = 4'd3;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] reply_char(input reply_code_t code, input reply_idx_t idx);
        logic [7:0] ch;
        ch = CH_CR;
        unique case (code)
            REPLY_OK: begin
                case (idx)
                    4'd0:    ch = CH_O;
                    4'd1:    ch = CH_K;
                    default: ch = CH_CR;
                endcase
            end
            REPLY_MM: begin
                case (idx)
                    4'd0:    ch = CH_M;
                    4'd1:    ch = CH_M;
                    4'd2:    ch = CH_SPACE;
                    4'd3:    ch = CH_B;
                    4'd4:    ch = CH_FIVE;
                    4'd6:    ch = CH_M;
                    4'd7:    ch = CH_P;
                    default: ch = CH_CR;
                endcase
            end
            REPLY_TE: begin
                case (idx)
                    4'd0:    ch = CH_T;
                    4'd1:    ch = CH_E;
                    default: ch = CH_CR;
                endcase
            end
            default: ch = CH_CR;
        endcase
        return ch;
    endfunction

endpackage

FILE: src/text_command_line_responder.sv
// Text command line responder: line collection, command matching, reply sequencing and blink timer.
//
// Ordinary bytes and timer ticks are taken one per cycle; a byte adds to the line store and
// gives no result, a tick gives one status result. A carriage return that draws a reply holds
// the request side off until the last reply byte has entered the output register. The replies
// are "OK\r", "TE\r" and "MM B5\rMP\r"; the reply sequencer feeds them one byte per cycle into
// the single output register while the output is not stalled. A stalled output stalls the
// input only when a result is waiting and cannot move.
module text_command_line_responder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_reply_byte,
    output logic       m_has_byte,
    output logic       m_last,
    output logic       m_blink_level,
    output logic       m_tie_level
);
    import tclr_pkg::*;

    logic [7:0]       line_store_reg [LINE_DEPTH];
    logic [LEN_W-1:0] line_length_reg, line_length_next;
    logic [3:0]       blink_period_reg, blink_period_next;
    logic [3:0]       tick_count_reg, tick_count_next;
    logic             blink_pin_reg, blink_pin_next;
    logic             tie_pin_reg, tie_pin_next;

    logic             gen_active_reg, gen_active_next;
    reply_code_t      gen_code_reg, gen_code_next;
    reply_idx_t       gen_idx_reg, gen_idx_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_reply_byte_reg, m_reply_byte_next;
    logic             m_has_byte_reg, m_has_byte_next;
    logic             m_last_reg, m_last_next;
    logic             m_blink_level_reg, m_blink_level_next;
    logic             m_tie_level_reg, m_tie_level_next;

    logic             accept;
    logic             out_free;
    logic             append;
    logic [3:0]       tick_inc;
    logic             is_ok_line, is_st_line, is_okq_line, is_pl_line;
    logic             has_room;

    function automatic logic line_is2(input logic [7:0] a, input logic [7:0] b,
                                      input logic [LEN_W-1:0] len,
                                      input logic [7:0] c0, input logic [7:0] c1);
        return (len == LEN_W'(2)) && (c0 == a) && (c1 == b);
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !gen_active_reg && out_free;
    assign accept   = s_valid && s_ready;
    assign has_room = line_length_reg < LEN_W'(LINE_DEPTH);
    assign append   = accept && !s_command && (s_rx_byte != CH_CR) && has_room;
    assign tick_inc = tick_count_reg + 4'd1;

    // Only the first five stored bytes take part in matching; longer lines never match.
    always_comb begin
        logic [7:0] c0, c1, c2, c3, c4;
        c0 = line_store_reg[0];
        c1 = line_store_reg[1];
        c2 = line_store_reg[2];
        c3 = line_store_reg[3];
        c4 = line_store_reg[4];
        is_ok_line =
            line_is2(CH_A, CH_T, line_length_reg, c0, c1) ||
            line_is2(CH_N, CH_G, line_length_reg, c0, c1) ||
            line_is2(CH_E, CH_G, line_length_reg, c0, c1) ||
            line_is2(CH_P, CH_S, line_length_reg, c0, c1) ||
            line_is2(CH_W, CH_N, line_length_reg, c0, c1) ||
            ((line_length_reg == LEN_W'(3)) && c0 == CH_R && c1 == CH_S && c2 == CH_T) ||
            ((line_length_reg == LEN_W'(4)) && c0 == CH_S && c1 == CH_P && c2 == CH_SPACE &&
             (c3 == CH_B || c3 == CH_W)) ||
            ((line_length_reg == LEN_W'(5)) && c0 == CH_M && c1 == CH_V && c2 == CH_SPACE &&
             c3 >= CH_A && c3 <= CH_H && c4 >= CH_ONE && c4 <= CH_EIGHT);
        is_st_line = (line_length_reg == LEN_W'(4)) && c0 == CH_S && c1 == CH_T &&
                     c2 == CH_SPACE && c3 >= CH_ONE && c3 <= CH_NINE;
        is_okq_line = line_is2(CH_O, CH_K, line_length_reg, c0, c1);
        is_pl_line  = line_is2(CH_P, CH_L, line_length_reg, c0, c1);
    end

    always_comb begin
        line_length_next   = line_length_reg;
        blink_period_next  = blink_period_reg;
        tick_count_next    = tick_count_reg;
        blink_pin_next     = blink_pin_reg;
        tie_pin_next       = tie_pin_reg;
        gen_active_next    = gen_active_reg;
        gen_code_next      = gen_code_reg;
        gen_idx_next       = gen_idx_reg;
        m_valid_next       = m_valid_reg;
        m_reply_byte_next  = m_reply_byte_reg;
        m_has_byte_next    = m_has_byte_reg;
        m_last_next        = m_last_reg;
        m_blink_level_next = m_blink_level_reg;
        m_tie_level_next   = m_tie_level_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (gen_active_reg && out_free) begin
            m_valid_next       = 1'b1;
            m_reply_byte_next  = reply_char(gen_code_reg, gen_idx_reg);
            m_has_byte_next    = 1'b1;
            m_last_next        = (gen_idx_reg == reply_len(gen_code_reg) - 4'd1);
            m_blink_level_next = blink_pin_reg;
            m_tie_level_next   = tie_pin_reg;
            gen_idx_next       = gen_idx_reg + 4'd1;
            if (gen_idx_reg == reply_len(gen_code_reg) - 4'd1) begin
                gen_active_next = 1'b0;
            end
        end

        if (accept) begin
            if (s_command) begin
                tick_count_next = tick_inc;
                if (tick_inc >= blink_period_reg) begin
                    tick_count_next = 4'd0;
                    blink_pin_next  = !blink_pin_reg;
                end
                m_valid_next       = 1'b1;
                m_reply_byte_next  = 8'd0;
                m_has_byte_next    = 1'b0;
                m_last_next        = 1'b1;
                m_blink_level_next = blink_pin_next;
                m_tie_level_next   = tie_pin_reg;
            end else if (s_rx_byte != CH_CR) begin
                if (has_room) begin
                    line_length_next = line_length_reg + LEN_W'(1);
                end
            end else begin
                line_length_next = '0;
                if (is_ok_line) begin
                    gen_code_next   = REPLY_OK;
                    gen_active_next = 1'b1;
                end else if (is_st_line) begin
                    blink_period_next = line_store_reg[3][3:0];
                end else if (is_okq_line) begin
                    gen_code_next   = REPLY_MM;
                    gen_active_next = 1'b1;
                end else if (!is_pl_line) begin
                    gen_code_next   = REPLY_TE;
                    gen_active_next = 1'b1;
                    tie_pin_next    = 1'b0;
                end
                if (gen_active_next) begin
                    // The first reply byte goes straight to the output; the sequencer does the rest.
                    m_valid_next       = 1'b1;
                    m_reply_byte_next  = reply_char(gen_code_next, 4'd0);
                    m_has_byte_next    = 1'b1;
                    m_last_next        = 1'b0;
                    m_blink_level_next = blink_pin_reg;
                    m_tie_level_next   = tie_pin_next;
                    gen_idx_next       = 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg  <= '0;
            blink_period_reg <= BLINK_PERIOD_RESET;
            tick_count_reg   <= 4'd0;
            blink_pin_reg    <= 1'b1;
            tie_pin_reg      <= 1'b1;
            gen_active_reg   <= 1'b0;
            gen_code_reg     <= REPLY_OK;
            gen_idx_reg      <= 4'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            line_length_reg  <= line_length_next;
            blink_period_reg <= blink_period_next;
            tick_count_reg   <= tick_count_next;
            blink_pin_reg    <= blink_pin_next;
            tie_pin_reg      <= tie_pin_next;
            gen_active_reg   <= gen_active_next;
            gen_code_reg     <= gen_code_next;
            gen_idx_reg      <= gen_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reply_byte_reg  <= m_reply_byte_next;
        m_has_byte_reg    <= m_has_byte_next;
        m_last_reg        <= m_last_next;
        m_blink_level_reg <= m_blink_level_next;
        m_tie_level_reg   <= m_tie_level_next;
    end

    // Bytes beyond the store are dropped; entries past the line length never affect a match.
    always_ff @(posedge aclk) begin
        if (append) begin
            line_store_reg[line_length_reg[IDX_W-1:0]] <= s_rx_byte;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_byte  = m_reply_byte_reg;
    assign m_has_byte    = m_has_byte_reg;
    assign m_last        = m_last_reg;
    assign m_blink_level = m_blink_level_reg;
    assign m_tie_level   = m_tie_level_reg;

    a_gen_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_active_reg |-> m_valid_reg)
        else $error("reply sequencer active without a result in the output register");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_length_reg <= LEN_W'(LINE_DEPTH))
        else $error("line length beyond the line store");

    a_tie_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !tie_pin_reg |=> !tie_pin_reg)
        else $error("tie pin rose again without reset");

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        blink_period_reg != 4'd0)
        else $error("blink period is zero");

    a_reply_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("reply broken off before its last byte");

endmodule
